// ===== rtl/core/odt_pkg.sv =====
// odt_pkg: shared widths, constants, mode codes and beat types of the one-shot delay timer
// no dependencies
`timescale 1ns / 1ps

package odt_pkg;

    localparam int COUNTER_SPAN = 65536;
    localparam int SPAN_BITS    = $clog2(COUNTER_SPAN);

    localparam int TPU_W   = 8;
    localparam int DELAY_W = 26;
    localparam int PROD_W  = DELAY_W + TPU_W;
    localparam int PSC_W   = 17;
    localparam int REL_W   = 16;
    localparam int QCNT_W  = $clog2(PROD_W + 1);

    localparam logic [TPU_W-1:0] TPU_RESET    = TPU_W'(64);
    localparam logic [PSC_W-1:0] PRESCALE_MAX = {PSC_W{1'b1}};
    localparam logic [REL_W-1:0] RELOAD_MAX   = {REL_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SCHED = 2'd1,
        MODE_ABORT = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [DELAY_W-1:0] delay_us;
    } in_t;

    typedef struct packed {
        logic fired;
        logic armed;
    } out_t;

    typedef struct packed {
        logic             tick;
        logic             abort;
        logic             load;
        logic [PSC_W-1:0] psc;
        logic [REL_W-1:0] rel;
    } cnt_cmd_t;

    typedef struct packed {
        logic fired;
        logic armed_next;
    } cnt_stat_t;

endpackage

// ===== rtl/core/odt_divider.sv =====
// odt_divider: restoring divider, one quotient bit per cycle
// depends on odt_pkg
`timescale 1ns / 1ps

module odt_divider
    import odt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PSC_W-1:0]  divisor,
    output logic [PROD_W-1:0] quotient,
    output logic              done
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PSC_W-1:0]  rem_reg, rem_next;
    logic [PSC_W-1:0]  dvs_reg, dvs_next;
    logic [PSC_W:0]    trial;
    logic [PSC_W:0]    diff;

    // shifted partial remainder and its trial subtraction
    assign trial = {rem_reg, acc_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[PSC_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PSC_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + QCNT_W'(1);
            if (cnt_reg == QCNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = acc_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/odt_counter.sv =====
// odt_counter: prescale and main counters, pending flag and fire detection
// depends on odt_pkg
`timescale 1ns / 1ps

module odt_counter
    import odt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cnt_cmd_t  cmd,
    output cnt_stat_t stat
);

    logic             pending_reg, pending_next;
    logic [PSC_W-1:0] psc_lim_reg, psc_lim_next;
    logic [REL_W-1:0] rel_lim_reg, rel_lim_next;
    logic [PSC_W-1:0] pc_reg, pc_next;
    logic [REL_W-1:0] mc_reg, mc_next;
    logic [PSC_W-1:0] pc_inc;
    logic [REL_W-1:0] mc_inc;
    logic             fired;

    // counts stay below their limits, so the increments never wrap
    assign pc_inc = pc_reg + PSC_W'(1);
    assign mc_inc = mc_reg + REL_W'(1);

    always_comb
    begin
        pending_next = pending_reg;
        psc_lim_next = psc_lim_reg;
        rel_lim_next = rel_lim_reg;
        pc_next      = pc_reg;
        mc_next      = mc_reg;
        fired        = 1'b0;
        if (cmd.load)
        begin
            psc_lim_next = cmd.psc;
            rel_lim_next = cmd.rel;
            pc_next      = '0;
            mc_next      = '0;
            pending_next = 1'b1;
        end
        else if (cmd.abort)
        begin
            pending_next = 1'b0;
        end
        else if (cmd.tick && pending_reg)
        begin
            if (pc_inc < psc_lim_reg)
            begin
                pc_next = pc_inc;
            end
            else
            begin
                pc_next = '0;
                if (mc_inc < rel_lim_reg)
                begin
                    mc_next = mc_inc;
                end
                else
                begin
                    mc_next      = '0;
                    pending_next = 1'b0;
                    fired        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            psc_lim_reg <= '0;
            rel_lim_reg <= '0;
            pc_reg      <= '0;
            mc_reg      <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            psc_lim_reg <= psc_lim_next;
            rel_lim_reg <= rel_lim_next;
            pc_reg      <= pc_next;
            mc_reg      <= mc_next;
        end
    end

    assign stat.fired      = fired;
    assign stat.armed_next = pending_next;

endmodule

// ===== rtl/core/one_shot_delay_timer_unit.sv =====
// one_shot_delay_timer_unit: top level, schedule sequencer, config register and output register
// depends on odt_pkg, odt_counter, odt_divider
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_data   (mode, delay_us)
// out       output     out_valid/out_ready  out_data  (fired, armed)
// cfg       input      cfg_we               cfg_wdata (ticks_per_us)
//
// tick, abort and unused-mode beats are taken one per clock while no schedule is being worked on and out drains
// a schedule beat is worked on in steps: one multiply, one prescaler step, then the
// reload divide in the divider at one quotient bit per cycle (34 bits)
// in_ready is low while a schedule is being worked on or the output register is held
// reset is asynchronous, active low; ticks_per_us returns to 64, nothing is armed

module one_shot_delay_timer_unit
    import odt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TPU_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_PSC  = 4'b0100,
        ST_DIV  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [TPU_W-1:0]   tpu_reg;
    logic [DELAY_W-1:0] d_reg;
    logic [TPU_W-1:0]   t_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic                      accept;
    logic [PROD_W-SPAN_BITS:0] psc_wide;
    logic [PSC_W-1:0]          psc;
    logic                      div_start;
    logic [PROD_W-1:0]         quotient;
    logic                      div_done;
    logic [REL_W-1:0]          rel;
    cnt_cmd_t                  cmd;
    cnt_stat_t                 stat;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // prescaler from the registered product, or the rate itself for short delays
    assign psc_wide = {1'b0, prod_reg[PROD_W-1:SPAN_BITS]} + (PROD_W-SPAN_BITS+1)'(1);
    always_comb
    begin
        if (d_reg < DELAY_W'(COUNTER_SPAN))
            psc = PSC_W'(t_reg);
        else if (psc_wide > (PROD_W-SPAN_BITS+1)'(PRESCALE_MAX))
            psc = PRESCALE_MAX;
        else
            psc = psc_wide[PSC_W-1:0];
    end

    assign div_start = (state_reg == ST_PSC);

    odt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (psc),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        if (quotient > PROD_W'(RELOAD_MAX))
            rel = RELOAD_MAX;
        else if (quotient == '0)
            rel = REL_W'(1);
        else
            rel = quotient[REL_W-1:0];
    end

    always_comb
    begin
        cmd.tick  = accept && (in_data.mode == MODE_TICK);
        cmd.abort = accept && (in_data.mode == MODE_ABORT);
        cmd.load  = (state_reg == ST_DIV) && div_done;
        cmd.psc   = psc;
        cmd.rel   = rel;
    end

    odt_counter u_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.mode == MODE_SCHED))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_PSC;
            end
            ST_PSC:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (accept && (in_data.mode != MODE_SCHED))
        begin
            out_valid_next       = 1'b1;
            out_data_next.fired  = stat.fired;
            out_data_next.armed  = stat.armed_next;
        end
        else if (cmd.load)
        begin
            out_valid_next       = 1'b1;
            out_data_next.fired  = 1'b0;
            out_data_next.armed  = stat.armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tpu_reg       <= TPU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                tpu_reg <= cfg_wdata;
        end
    end

    // schedule operands; zero delay and zero rate both clamp to one
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept && (in_data.mode == MODE_SCHED))
        begin
            d_reg <= (in_data.delay_us == '0) ? DELAY_W'(1) : in_data.delay_us;
            t_reg <= (tpu_reg == '0) ? TPU_W'(1) : tpu_reg;
        end
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'(d_reg) * PROD_W'(t_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== dv/one_shot_delay_timer_unit_test.sv =====
// one_shot_delay_timer_unit_test: self-checking bench for the one-shot delay timer
// directed table then random schedule/tick/abort traffic, checked against an in-bench timer model
// depends on odt_pkg and one_shot_delay_timer_unit
`timescale 1ns / 1ps

module one_shot_delay_timer_unit_test;
    import odt_pkg::*;

    localparam int IDLE_PCT      = 7;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        mode_t              mode;
        logic [DELAY_W-1:0] arg;
        int unsigned        reps;
        bit                 typed;
        out_t               want;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [TPU_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;

    // timer model state
    logic [TPU_W-1:0] tm_tpu;
    logic             tm_pending;
    logic [PSC_W-1:0] tm_psc_lim;
    logic [REL_W-1:0] tm_rel_lim;
    logic [PSC_W-1:0] tm_psc_cnt;
    logic [REL_W-1:0] tm_main_cnt;

    out_t      expected_status_q[$];
    plan_row_t plan_q[$];
    int        mismatch_count;
    int        cycle_count;
    bit        steady;

    one_shot_delay_timer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // derive prescaler and reload for a new delay and restart the counts
    function automatic void timer_load(input logic [DELAY_W-1:0] delay);
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] prod;
        logic [63:0] psc;
        logic [63:0] rel;
        d = 64'(delay);
        t = 64'(tm_tpu);
        if (d == 64'd0)
            d = 64'd1;
        if (t == 64'd0)
            t = 64'd1;
        prod = d * t;
        if (d < 64'(COUNTER_SPAN))
            psc = t;
        else
            psc = prod / 64'(COUNTER_SPAN) + 64'd1;
        if (psc > 64'(PRESCALE_MAX))
            psc = 64'(PRESCALE_MAX);
        rel = prod / psc;
        if (rel > 64'(RELOAD_MAX))
            rel = 64'(RELOAD_MAX);
        if (rel == 64'd0)
            rel = 64'd1;
        tm_psc_lim  = PSC_W'(psc);
        tm_rel_lim  = REL_W'(rel);
        tm_psc_cnt  = '0;
        tm_main_cnt = '0;
        tm_pending  = 1'b1;
    endfunction

    function automatic out_t timer_advance(input in_t b);
        out_t res;
        res = '0;
        case (b.mode)
            MODE_TICK:
            begin
                if (tm_pending)
                begin
                    tm_psc_cnt = tm_psc_cnt + PSC_W'(1);
                    if (tm_psc_cnt >= tm_psc_lim)
                    begin
                        tm_psc_cnt  = '0;
                        tm_main_cnt = tm_main_cnt + REL_W'(1);
                        if (tm_main_cnt >= tm_rel_lim)
                        begin
                            tm_main_cnt = '0;
                            tm_pending  = 1'b0;
                            res.fired   = 1'b1;
                        end
                    end
                end
            end
            MODE_SCHED: timer_load(b.delay_us);
            MODE_ABORT: tm_pending = 1'b0;
            default: ;
        endcase
        res.armed = tm_pending;
        return res;
    endfunction

    function automatic void plan(input row_kind_t kind, input mode_t mode,
                                 input logic [DELAY_W-1:0] arg, input int unsigned reps,
                                 input bit typed, input logic fired, input logic armed);
        plan_row_t row;
        row.kind       = kind;
        row.mode       = mode;
        row.arg        = arg;
        row.reps       = reps;
        row.typed      = typed;
        row.want.fired = fired;
        row.want.armed = armed;
        plan_q.push_back(row);
    endfunction

    // queue the expected status, then hold the beat until it is taken
    task automatic issue_beat(input mode_t mode, input logic [DELAY_W-1:0] delay,
                              input bit typed, input out_t want);
        in_t  b;
        out_t predicted;
        b.mode     = mode;
        b.delay_us = delay;
        predicted  = timer_advance(b);
        expected_status_q.push_back(typed ? want : predicted);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tpu(input logic [TPU_W-1:0] value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tm_tpu = value;
    endtask

    task automatic note_mismatch(input string what, input int expv, input int actv);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d at cycle %0d",
                     what, expv, actv, cycle_count);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
                note_mismatch("unexpected beat, fired", -1, int'(out_data.fired));
            else
            begin
                exp_res = expected_status_q.pop_front();
                if (out_data.fired !== exp_res.fired)
                    note_mismatch("fired", int'(exp_res.fired), int'(out_data.fired));
                if (out_data.armed !== exp_res.armed)
                    note_mismatch("armed", int'(exp_res.armed), int'(out_data.armed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        plan_row_t   row;
        int unsigned live_items;
        int unsigned ticks;
        int unsigned tick_bound;
        int unsigned pick;
        logic [DELAY_W-1:0] delay;
        logic [TPU_W-1:0]   tpu;
        bit          big;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        steady          = 1'b0;
        tm_tpu          = TPU_RESET;
        tm_pending      = 1'b0;
        tm_psc_lim      = '0;
        tm_rel_lim      = '0;
        tm_psc_cnt      = '0;
        tm_main_cnt     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of ticks_per_us is 64
        plan(ROW_BEAT, MODE_TICK,  '0, 1, 1'b1, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_ABORT, '0, 1, 1'b1, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_RSVD,  '1, 1, 1'b1, 1'b0, 1'b0);
        // zero delay clamps to one us: 64 ticks
        plan(ROW_BEAT, MODE_SCHED, '0, 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 63, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_TICK,  '0, 1, 1'b1, 1'b1, 1'b0);
        // reschedule while armed cancels the long one
        plan(ROW_BEAT, MODE_SCHED, '1, 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_SCHED, DELAY_W'(5), 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 320, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_SCHED, DELAY_W'(65535), 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_ABORT, '0, 1, 1'b1, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_TICK,  '0, 1, 1'b1, 1'b0, 1'b0);
        // widest rate: prescaler and reload both saturate on the max delay
        plan(ROW_CFG,  MODE_TICK,  DELAY_W'(255), 1, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_SCHED, DELAY_W'(65536), 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 100, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_SCHED, '1, 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 50, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_ABORT, '0, 1, 1'b1, 1'b0, 1'b0);
        // one tick per us, long-delay path: prescaler 2, reload 32768, aborted early
        plan(ROW_CFG,  MODE_TICK,  DELAY_W'(1), 1, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_SCHED, DELAY_W'(65536), 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 40, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_ABORT, '0, 1, 1'b1, 1'b0, 1'b0);
        // zero rate acts as one
        plan(ROW_CFG,  MODE_TICK,  DELAY_W'(0), 1, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_SCHED, DELAY_W'(3), 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 2, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_TICK,  '0, 1, 1'b1, 1'b1, 1'b0);
        // rate change while armed leaves the running event alone
        plan(ROW_CFG,  MODE_TICK,  DELAY_W'(2), 1, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_SCHED, DELAY_W'(10), 1, 1'b1, 1'b0, 1'b1);
        plan(ROW_BEAT, MODE_TICK,  '0, 5, 1'b0, 1'b0, 1'b0);
        plan(ROW_CFG,  MODE_TICK,  DELAY_W'(7), 1, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_TICK,  '0, 14, 1'b0, 1'b0, 1'b0);
        plan(ROW_BEAT, MODE_TICK,  '0, 1, 1'b1, 1'b1, 1'b0);

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.kind == ROW_CFG)
                write_tpu(TPU_W'(row.arg));
            else
                repeat (row.reps) issue_beat(row.mode, row.arg, row.typed, row.want);
        end

        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            steady = (live_items >= 300 && live_items < 600);
            if ($urandom_range(0, 5) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    tpu = TPU_W'(1);
                else if (pick == 1)
                    tpu = TPU_W'(255);
                else if (pick == 2)
                    tpu = TPU_W'($urandom_range(1, 255));
                else
                    tpu = TPU_W'($urandom_range(1, 6));
                write_tpu(tpu);
            end
            else if ($urandom_range(0, 7) == 0)
                hold_until_drained();

            big = ($urandom_range(0, 9) == 0);
            if (big)
                delay = DELAY_W'($urandom());
            else if (tm_tpu > TPU_W'(16))
                delay = DELAY_W'($urandom_range(0, 1));
            else
                delay = DELAY_W'($urandom_range(0, 16));
            issue_beat(MODE_SCHED, delay, 1'b0, '0);
            live_items++;

            // ticks with some noise until the event fires or is aborted, or the bound hits
            tick_bound = big ? 30 : 600;
            ticks = 0;
            while (tm_pending && ticks < tick_bound)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    issue_beat(MODE_ABORT, DELAY_W'($urandom()), 1'b0, '0);
                else if (pick < 5)
                    issue_beat(MODE_RSVD, DELAY_W'($urandom()), 1'b0, '0);
                else if (pick < 7)
                    issue_beat(MODE_SCHED, DELAY_W'($urandom_range(0, 8)), 1'b0, '0);
                else
                    issue_beat(MODE_TICK, DELAY_W'($urandom()), 1'b0, '0);
                if (pick >= 2 && pick < 5)
                    continue;
                ticks++;
                live_items++;
            end
            if (tm_pending)
            begin
                issue_beat(MODE_ABORT, '0, 1'b0, '0);
                live_items++;
            end
            repeat ($urandom_range(0, 3)) issue_beat(MODE_TICK, '0, 1'b0, '0);
        end
        steady = 1'b0;

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== one_shot_delay_timer_unit.f =====
rtl/core/odt_pkg.sv
rtl/core/odt_divider.sv
rtl/core/odt_counter.sv
rtl/core/one_shot_delay_timer_unit.sv
dv/one_shot_delay_timer_unit_test.sv
